[rtl/pn3d_pkg.sv]
package pn3d_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int MAX_OCT_DEF = 8;
  localparam int QDEPTH = 2;
  // width of every value on the blend chain
  localparam int VW = 26;
  localparam logic signed [31:0] ONE = 32'sd65536;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_NOISE = 2'd1;
  localparam logic [1:0] MODE_TURB = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_NOISE = 2'd1,
    CMD_TURB  = 2'd2
  } cmd_e_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [8:0]         entry_index;
    logic [7:0]         entry_value;
  } in_word_t;

  typedef struct packed {
    logic signed [17:0] noise_value;
    logic signed [23:0] deriv_x;
    logic signed [23:0] deriv_y;
    logic signed [23:0] deriv_z;
  } out_word_t;

  typedef struct packed {
    cmd_e_t             cmd;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [8:0]         idx;
    logic [7:0]         val;
  } cmd_t;

  function automatic logic signed [18:0] grad(logic [3:0] h, logic signed [17:0] dx,
                                              logic signed [17:0] dy,
                                              logic signed [17:0] dz);
    logic signed [18:0] u;
    logic signed [18:0] v;
    u = (h < 4'd8 || h == 4'd12 || h == 4'd13) ? 19'(dx) : 19'(dy);
    v = (h < 4'd4 || h == 4'd12 || h == 4'd13) ? 19'(dy) : 19'(dz);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  function automatic logic signed [17:0] sat18(logic signed [VW-1:0] v);
    logic signed [17:0] r;
    if (v > VW'(131071)) r = 18'sd131071;
    else if (v < VW'(-131072)) r = -18'sd131072;
    else r = v[17:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(logic signed [VW-1:0] v);
    logic signed [23:0] r;
    if (v > VW'(8388607)) r = 24'sd8388607;
    else if (v < VW'(-8388608)) r = -24'sd8388608;
    else r = v[23:0];
    return r;
  endfunction

endpackage

[rtl/perlin_noise_3d_with_gradient.sv]
// 3D improved Perlin noise on Q16.16 points. Load words (mode 0) write one byte
// of the 2*TABLE_SIZE-entry hash table without leaving the idle state; the
// table holds garbage until loaded. A noise word (mode 1) returns the value
// and its x, y, z derivatives; a turbulence word (mode 2) returns the
// octave-weighted sum, one noise pass per octave followed by a final rounding
// division. Cost is set by one shared multiplier and by the hash table's single
// read port, three dependent reads per cube corner. A two-word queue sits
// behind the input and an output register in front of the result, so input
// words are taken while a result waits. cfg_wr_data sets the octave count
// (0 acts as 1, values over MAX_OCTAVES clip); write it only while idle.
module perlin_noise_3d_with_gradient #(
  parameter int TABLE_SIZE  = pn3d_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = pn3d_pkg::MAX_OCT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pn3d_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pn3d_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data
);
  import pn3d_pkg::*;

  logic push, q_full, pop, q_valid;
  cmd_t push_data, q_data;

  pn3d_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .q_full(q_full), .push(push), .push_data(push_data)
  );

  pn3d_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .full(q_full), .pop(pop), .q_valid(q_valid), .q_data(q_data)
  );

  pn3d_back #(.TABLE_SIZE(TABLE_SIZE), .MAX_OCTAVES(MAX_OCTAVES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .pop(pop),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );
endmodule

[rtl/pn3d_ram.sv]
module pn3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/pn3d_front.sv]
module pn3d_front #(
  parameter int TABLE_SIZE = pn3d_pkg::TABLE_SIZE_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  pn3d_pkg::in_word_t in_word,
  input  logic               q_full,
  output logic               push,
  output pn3d_pkg::cmd_t     push_data
);
  import pn3d_pkg::*;

  localparam int ENTRIES = 2 * TABLE_SIZE;

  logic   keep;
  cmd_e_t cmd;

  assign in_stall = q_full;

  // drop unknown modes and loads beyond the table
  always_comb begin
    keep = 1'b0;
    cmd  = CMD_NOISE;
    unique case (in_word.mode)
      MODE_LOAD: begin
        keep = 32'(in_word.entry_index) < ENTRIES;
        cmd  = CMD_LOAD;
      end
      MODE_NOISE: begin
        keep = 1'b1;
        cmd  = CMD_NOISE;
      end
      MODE_TURB: begin
        keep = 1'b1;
        cmd  = CMD_TURB;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = in_valid & ~q_full & keep;
  assign push_data = '{cmd: cmd, cx: in_word.coord_x, cy: in_word.coord_y,
                       cz: in_word.coord_z, idx: in_word.entry_index,
                       val: in_word.entry_value};
endmodule

[rtl/pn3d_queue.sv]
module pn3d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pn3d_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output pn3d_pkg::cmd_t q_data
);
  import pn3d_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNW = $clog2(QDEPTH + 1);

  cmd_t           mem_r [QDEPTH];
  logic [PW-1:0]  wp_r;
  logic [PW-1:0]  rp_r;
  logic [CNW-1:0] cnt_r;

  function automatic logic [PW-1:0] nxt(logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full = cnt_r == CNW'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= nxt(wp_r);
      if (pop) rp_r <= nxt(rp_r);
      if (push && !pop) cnt_r <= cnt_r + CNW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNW'(1);
    end
  end
endmodule

[rtl/pn3d_back.sv]
module pn3d_back #(
  parameter int TABLE_SIZE  = pn3d_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = pn3d_pkg::MAX_OCT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pn3d_pkg::cmd_t      q_data,
  output logic                pop,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pn3d_pkg::out_word_t out_word
);
  import pn3d_pkg::*;

  localparam int ENTRIES = 2 * TABLE_SIZE;
  localparam int AW = $clog2(ENTRIES);
  localparam int TW = $clog2(TABLE_SIZE);
  localparam int SW = ((TW > 8) ? TW : 8) + 1;
  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W = VW + MAX_OCTAVES + 1;
  localparam int NW = ACC_W + 2;
  localparam int TOTW = MAX_OCTAVES + 1;
  localparam int DW = MAX_OCTAVES + 2;
  localparam int CW = $clog2(NW);
  localparam int NMAX = 131071;
  localparam int NMIN = -131072;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FADE  = 8'b0000_0010,
    S_HASH  = 8'b0000_0100,
    S_BLEND = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_DPREP = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r;
  logic [3:0] oc_r;
  logic turb_r;
  logic [31:0] cx_r, cy_r, cz_r;
  logic [4:0] st_r;
  logic ph_r;
  logic [2:0] crn_r;
  logic [1:0] hp_r;
  logic [OW-1:0] oct_r, noct_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [TOTW-1:0] tot_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic neg_r;
  logic [CW-1:0] dcnt_r;
  logic signed [50:0] prod_r;

  logic signed [VW-1:0] w_r [8];
  logic signed [VW-1:0] xw_r [4];
  logic signed [VW-1:0] xyw_r [2];
  logic signed [VW-1:0] g_r [4];
  logic signed [VW-1:0] gy_r [2];
  logic signed [VW-1:0] d_r [3];
  logic signed [VW-1:0] f_r [3];
  logic signed [VW-1:0] dd_r [3];
  logic signed [VW-1:0] nv_r, q_r, m_r;

  logic out_valid_r;
  out_word_t out_word_r;

  // hash table
  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [7:0] ram_rd;

  pn3d_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(q_data.val),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  assign pop = (state_r == S_IDLE) && q_valid;
  assign ram_we = pop && (q_data.cmd == CMD_LOAD);
  assign ram_wa = AW'(q_data.idx);

  function automatic logic signed [31:0] dif(logic signed [VW-1:0] b,
                                             logic signed [VW-1:0] a);
    return 32'(b) - 32'(a);
  endfunction

  // shared multiply: operand select per step
  logic signed [31:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [VW-1:0] mul_c;
  logic [15:0] tk;
  logic [1:0] fk;
  logic [4:0] fj;
  logic signed [50:0] rnd_full;
  logic signed [VW-1:0] res;

  always_comb begin
    fj = st_r - 5'd12;
    fk = (st_r < 5'd12) ? st_r[3:2] : fj[2:1];
    unique case (fk)
      2'd0: tk = cx_r[15:0];
      2'd1: tk = cy_r[15:0];
      default: tk = cz_r[15:0];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    if (state_r == S_FADE) begin
      if (st_r < 5'd12) begin
        mul_b = $signed({3'b000, tk});
        if (st_r[1:0] == 2'd0) begin
          mul_a = $signed(32'(tk)) * 32'sd6 - 32'sd983040;
          mul_c = VW'(655360);
        end else begin
          mul_a = 32'(q_r);
        end
      end else if (!fj[0]) begin
        mul_a = $signed(32'(tk));
        mul_b = $signed(19'(17'h10000 - {1'b0, tk}));
      end else begin
        mul_a = 32'(m_r) * 32'sd30;
        mul_b = $signed(m_r[18:0]);
      end
    end else begin
      unique case (st_r)
        5'd0, 5'd1, 5'd2, 5'd3: begin
          mul_a = dif(w_r[st_r[1:0] + 3'd4], w_r[st_r[1:0]]);
          mul_b = $signed(f_r[0][18:0]);
          mul_c = w_r[st_r[1:0]];
        end
        5'd4, 5'd5: begin
          mul_a = dif(xw_r[{1'b1, st_r[0]}], xw_r[{1'b0, st_r[0]}]);
          mul_b = $signed(f_r[1][18:0]);
          mul_c = xw_r[{1'b0, st_r[0]}];
        end
        5'd6: begin
          mul_a = dif(xyw_r[1], xyw_r[0]);
          mul_b = $signed(f_r[2][18:0]);
          mul_c = xyw_r[0];
        end
        5'd7, 5'd8, 5'd9, 5'd10: begin
          mul_a = dif(w_r[fj[1:0] + 3'd4], w_r[fj[1:0]]);
          mul_b = $signed(dd_r[0][18:0]);
        end
        5'd11, 5'd12: begin
          mul_a = dif(g_r[{1'b1, ~st_r[0]}], g_r[{1'b0, ~st_r[0]}]);
          mul_b = $signed(f_r[1][18:0]);
          mul_c = g_r[{1'b0, ~st_r[0]}];
        end
        5'd13, 5'd16: begin
          mul_a = dif(gy_r[1], gy_r[0]);
          mul_b = $signed(f_r[2][18:0]);
          mul_c = gy_r[0];
        end
        5'd14, 5'd15: begin
          mul_a = dif(xw_r[{1'b1, st_r[0]}], xw_r[{1'b0, st_r[0]}]);
          mul_b = $signed(dd_r[1][18:0]);
        end
        default: begin
          mul_a = dif(xyw_r[1], xyw_r[0]);
          mul_b = $signed(dd_r[2][18:0]);
        end
      endcase
    end
  end

  assign rnd_full = (prod_r + 51'sd32768) >>> 16;
  assign res = mul_c + rnd_full[VW-1:0];

  // corner addressing
  logic [TW-1:0] xi, yi, zi;
  logic [SW-1:0] sum_y, sum_z;
  logic signed [17:0] gdx, gdy, gdz;
  logic signed [18:0] gval;

  assign xi = cx_r[16 +: TW] + TW'(crn_r[2]);
  assign yi = cy_r[16 +: TW] + TW'(crn_r[1]);
  assign zi = cz_r[16 +: TW] + TW'(crn_r[0]);
  assign sum_y = SW'(ram_rd) + SW'(yi);
  assign sum_z = SW'(ram_rd) + SW'(zi);

  always_comb begin
    unique case (hp_r)
      2'd0: ram_ra = AW'(xi);
      2'd1: ram_ra = sum_y[AW-1:0];
      default: ram_ra = sum_z[AW-1:0];
    endcase
  end

  assign gdx = $signed({2'b00, cx_r[15:0]}) - (crn_r[2] ? 18'sd65536 : 18'sd0);
  assign gdy = $signed({2'b00, cy_r[15:0]}) - (crn_r[1] ? 18'sd65536 : 18'sd0);
  assign gdz = $signed({2'b00, cz_r[15:0]}) - (crn_r[0] ? 18'sd65536 : 18'sd0);
  assign gval = grad(ram_rd[3:0], gdx, gdy, gdz);

  // octave bookkeeping and divider
  logic [OW-1:0] sh;
  logic [4:0] oc5;
  logic [OW-1:0] neff;
  logic [NW-1:0] num;
  logic [DW:0] rem_sh, den;
  logic ge;
  logic signed [NW:0] qs;
  logic signed [17:0] tq;
  logic can_load;

  assign sh = OW'(MAX_OCTAVES - 1) - oct_r;
  assign oc5 = {1'b0, oc_r};
  always_comb begin
    if (oc_r == 4'd0) neff = OW'(1);
    else if (oc5 > 5'(MAX_OCTAVES)) neff = OW'(MAX_OCTAVES);
    else neff = OW'(oc_r);
  end

  assign num = (NW'(acc_r) <<< 1) + NW'(tot_r);
  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign den = {1'b0, tot_r, 1'b0};
  assign ge = rem_sh >= den;
  assign qs = neg_r ? -($signed({1'b0, quo_r}) + (NW+1)'(rem_r != '0))
                    : $signed({1'b0, quo_r});
  always_comb begin
    if (qs > (NW+1)'(NMAX)) tq = 18'sd131071;
    else if (qs < (NW+1)'(NMIN)) tq = -18'sd131072;
    else tq = qs[17:0];
  end

  assign can_load = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oc_r <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) oc_r <= cfg_wr_data;
      if (state_r == S_OUT && can_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid && q_data.cmd != CMD_LOAD) state_r <= S_FADE;
        end
        S_FADE: begin
          if (ph_r && st_r == 5'd17) state_r <= S_HASH;
        end
        S_HASH: begin
          if (hp_r == 2'd3 && crn_r == 3'd7) state_r <= S_BLEND;
        end
        S_BLEND: begin
          if (ph_r && turb_r && st_r == 5'd6) state_r <= S_ACC;
          else if (ph_r && st_r == 5'd17) state_r <= S_OUT;
        end
        S_ACC: begin
          state_r <= (oct_r == noct_r - OW'(1)) ? S_DPREP : S_FADE;
        end
        S_DPREP: state_r <= S_DIV;
        S_DIV: begin
          if (dcnt_r == CW'(NW - 1)) state_r <= S_OUT;
        end
        S_OUT: begin
          if (can_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        turb_r <= q_data.cmd == CMD_TURB;
        cx_r <= q_data.cx;
        cy_r <= q_data.cy;
        cz_r <= q_data.cz;
        oct_r <= '0;
        noct_r <= neff;
        acc_r <= '0;
        tot_r <= '0;
        st_r <= '0;
        ph_r <= 1'b0;
      end
      S_FADE: begin
        ph_r <= ~ph_r;
        if (!ph_r) prod_r <= 51'(mul_a) * 51'(mul_b);
        else begin
          if (st_r < 5'd12) begin
            if (st_r[1:0] == 2'd3) f_r[fk] <= res;
            else q_r <= res;
          end else if (!fj[0]) m_r <= res;
          else dd_r[fk] <= res;
          if (st_r == 5'd17) begin
            st_r <= '0;
            crn_r <= '0;
            hp_r <= '0;
          end else st_r <= st_r + 5'd1;
        end
      end
      S_HASH: begin
        hp_r <= hp_r + 2'd1;
        if (hp_r == 2'd3) begin
          w_r[crn_r] <= VW'(gval);
          crn_r <= crn_r + 3'd1;
          ph_r <= 1'b0;
        end
      end
      S_BLEND: begin
        ph_r <= ~ph_r;
        if (!ph_r) prod_r <= 51'(mul_a) * 51'(mul_b);
        else begin
          unique case (st_r)
            5'd0, 5'd1, 5'd2, 5'd3: xw_r[st_r[1:0]] <= res;
            5'd4, 5'd5: xyw_r[st_r[0]] <= res;
            5'd6: nv_r <= res;
            5'd7, 5'd8, 5'd9, 5'd10: g_r[fj[1:0]] <= res;
            5'd11, 5'd12: gy_r[~st_r[0]] <= res;
            5'd13: d_r[0] <= res;
            5'd14, 5'd15: gy_r[st_r[0]] <= res;
            5'd16: d_r[1] <= res;
            default: d_r[2] <= res;
          endcase
          st_r <= st_r + 5'd1;
        end
      end
      S_ACC: begin
        acc_r <= acc_r + (ACC_W'(nv_r) <<< sh);
        tot_r <= tot_r + (TOTW'(1) << sh);
        oct_r <= oct_r + OW'(1);
        cx_r <= cx_r << 1;
        cy_r <= cy_r << 1;
        cz_r <= cz_r << 1;
        st_r <= '0;
        ph_r <= 1'b0;
      end
      S_DPREP: begin
        neg_r <= num[NW-1];
        quo_r <= num[NW-1] ? -num : num;
        rem_r <= '0;
        dcnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= ge ? DW'(rem_sh - den) : rem_sh[DW-1:0];
        quo_r <= {quo_r[NW-2:0], ge};
        dcnt_r <= dcnt_r + CW'(1);
      end
      S_OUT: begin
        if (can_load) begin
          if (turb_r) out_word_r <= '{noise_value: tq, deriv_x: '0, deriv_y: '0,
                                      deriv_z: '0};
          else out_word_r <= '{noise_value: sat18(nv_r), deriv_x: sat24(d_r[0]),
                                deriv_y: sat24(d_r[1]), deriv_z: sat24(d_r[2])};
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;
endmodule

[tb/tb_perlin_noise_3d_with_gradient.sv]
module tb_perlin_noise_3d_with_gradient;
  import pn3d_pkg::*;

  localparam int TSIZE   = 256;
  localparam int ENTRIES = 2 * TSIZE;
  localparam int MAXOCT  = 8;
  localparam longint UNIT = 65536;
  localparam longint OFFSET = longint'(1) <<< 60;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_wr_en;
  logic [3:0] cfg_wr_data;

  perlin_noise_3d_with_gradient uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic [7:0] perm [ENTRIES];
  logic [3:0] oct_reg;
  out_word_t  noise_due [$];
  int         fails;
  int         n_noise;
  int         n_turb;
  int         n_load;
  int         send_idle_pct;
  int         recv_stall_pct;
  bit         hold_recv;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #300000000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint round_shift(longint v, int s);
    longint b;
    b = v + OFFSET + (longint'(1) <<< (s - 1));
    return (b >>> s) - (OFFSET >>> s);
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + round_shift((b - a) * w, 16);
  endfunction

  function automatic longint fade_q(longint t);
    longint q;
    q = round_shift((6 * t - 15 * UNIT) * t, 16) + 10 * UNIT;
    q = round_shift(q * t, 16);
    q = round_shift(q * t, 16);
    return round_shift(q * t, 16);
  endfunction

  function automatic longint fade_slope(longint t);
    longint m;
    m = round_shift(t * (UNIT - t), 16);
    return round_shift(30 * m * m, 16);
  endfunction

  function automatic longint corner_dot(int unsigned ix, int unsigned iy, int unsigned iz,
                                        longint dx, longint dy, longint dz);
    int unsigned a, b;
    logic [3:0] h;
    longint u, v;
    a = 32'(perm[9'(ix % TSIZE)]);
    b = 32'(perm[9'((a + iy % TSIZE) % ENTRIES)]);
    h = perm[9'((b + iz % TSIZE) % ENTRIES)][3:0];
    u = (h < 8 || h == 12 || h == 13) ? dx : dy;
    v = (h < 4 || h == 12 || h == 13) ? dy : dz;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint sample_noise(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                          output longint gx, output longint gy,
                                          output longint gz);
    int unsigned ix, iy, iz, bx, by, bz;
    longint tx, ty, tz, fx, fy, fz, sx, sy, sz;
    longint w[8], xw[4], xyw[2], g[4], h2[2];
    ix = cx >> 16; iy = cy >> 16; iz = cz >> 16;
    tx = longint'(cx[15:0]); ty = longint'(cy[15:0]); tz = longint'(cz[15:0]);
    fx = fade_q(tx); fy = fade_q(ty); fz = fade_q(tz);
    for (int i = 0; i < 8; i++) begin
      bx = (i >> 2) & 1; by = (i >> 1) & 1; bz = i & 1;
      w[i] = corner_dot(ix + bx, iy + by, iz + bz,
                        tx - UNIT * bx, ty - UNIT * by, tz - UNIT * bz);
    end
    for (int i = 0; i < 4; i++) xw[i] = blend(w[i], w[i + 4], fx);
    for (int i = 0; i < 2; i++) xyw[i] = blend(xw[i], xw[i + 2], fy);
    sx = fade_slope(tx); sy = fade_slope(ty); sz = fade_slope(tz);
    for (int i = 0; i < 4; i++) g[i] = round_shift((w[i + 4] - w[i]) * sx, 16);
    for (int i = 0; i < 2; i++) h2[i] = blend(g[i], g[i + 2], fy);
    gx = blend(h2[0], h2[1], fz);
    for (int i = 0; i < 2; i++) h2[i] = round_shift((xw[i + 2] - xw[i]) * sy, 16);
    gy = blend(h2[0], h2[1], fz);
    gz = round_shift((xyw[1] - xyw[0]) * sz, 16);
    return blend(xyw[0], xyw[1], fz);
  endfunction

  function automatic longint clip(longint v, int width);
    longint hi;
    hi = (longint'(1) <<< (width - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint n2, d2, q;
    n2 = 2 * num + den;
    d2 = 2 * den;
    q = n2 / d2;
    if (n2 < 0 && q * d2 != n2) q -= 1;
    return q;
  endfunction

  task automatic predict(in_word_t w);
    out_word_t r;
    longint gx, gy, gz, n, acc, total, wt;
    int oc;
    case (w.mode)
      MODE_LOAD: begin
        perm[w.entry_index] = w.entry_value;
        n_load++;
      end
      MODE_NOISE: begin
        n = sample_noise(w.coord_x, w.coord_y, w.coord_z, gx, gy, gz);
        r.noise_value = 18'(clip(n, 18));
        r.deriv_x = 24'(clip(gx, 24));
        r.deriv_y = 24'(clip(gy, 24));
        r.deriv_z = 24'(clip(gz, 24));
        noise_due.push_back(r);
        n_noise++;
      end
      MODE_TURB: begin
        oc = int'(oct_reg);
        if (oc == 0) oc = 1;
        if (oc > MAXOCT) oc = MAXOCT;
        acc = 0; total = 0;
        for (int i = 0; i < oc; i++) begin
          wt = longint'(1) <<< (MAXOCT - 1 - i);
          n = sample_noise(w.coord_x << i, w.coord_y << i, w.coord_z << i, gx, gy, gz);
          acc += n * wt;
          total += wt;
        end
        r.noise_value = 18'(clip(div_round(acc, total), 18));
        r.deriv_x = '0; r.deriv_y = '0; r.deriv_z = '0;
        noise_due.push_back(r);
        n_turb++;
      end
      default: ;
    endcase
  endtask

  // drive one word and hold it until taken
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(w);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (noise_due.size() == 0) begin
          $error("unexpected result word");
          fails++;
        end else begin
          out_word_t e;
          e = noise_due.pop_front();
          if (out_word.noise_value !== e.noise_value) begin
            $error("noise_value exp %0d got %0d", e.noise_value, out_word.noise_value);
            fails++;
          end
          if (out_word.deriv_x !== e.deriv_x) begin
            $error("deriv_x exp %0d got %0d", e.deriv_x, out_word.deriv_x);
            fails++;
          end
          if (out_word.deriv_y !== e.deriv_y) begin
            $error("deriv_y exp %0d got %0d", e.deriv_y, out_word.deriv_y);
            fails++;
          end
          if (out_word.deriv_z !== e.deriv_z) begin
            $error("deriv_z exp %0d got %0d", e.deriv_z, out_word.deriv_z);
            fails++;
          end
        end
      end
      out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic drain;
    in_valid <= 1'b0;
    while (noise_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_octaves(logic [3:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    oct_reg = v;
  endtask

  function automatic in_word_t make_load(int idx, int val);
    in_word_t w;
    w = '0;
    w.mode = MODE_LOAD;
    w.entry_index = 9'(idx);
    w.entry_value = 8'(val);
    w.coord_x = $urandom; w.coord_y = $urandom; w.coord_z = $urandom;
    return w;
  endfunction

  function automatic in_word_t make_point(logic [1:0] m);
    in_word_t w;
    w.mode = m;
    w.entry_index = 9'($urandom);
    w.entry_value = 8'($urandom);
    case ($urandom_range(3))
      0: begin
        w.coord_x = $urandom; w.coord_y = $urandom; w.coord_z = $urandom;
      end
      1: begin
        w.coord_x = $urandom_range(32'h3ffff);
        w.coord_y = $urandom_range(32'h3ffff);
        w.coord_z = $urandom_range(32'h3ffff);
      end
      2: begin
        w.coord_x = {$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom)};
        w.coord_y = {16'($urandom), $urandom_range(1) ? 16'hffff : 16'h0};
        w.coord_z = {16'($urandom), 16'($urandom_range(1))};
      end
      default: begin
        w.coord_x = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        w.coord_y = $urandom;
        w.coord_z = $urandom_range(1) ? 32'hffffffff : 32'h0;
      end
    endcase
    return w;
  endfunction

  task automatic fill_table;
    for (int i = 0; i < ENTRIES; i++) send_word(make_load(i, $urandom_range(255)));
  endtask

  task automatic test_directed;
    in_word_t w;
    send_idle_pct = 0; recv_stall_pct = 0;
    fill_table();
    w = make_load(0, 8'hff); send_word(w);
    w = make_load(ENTRIES - 1, 8'h00); send_word(w);
    w = '0; w.mode = MODE_NOISE; send_word(w);
    w.coord_x = 32'h7fffffff; w.coord_y = 32'h80000000; w.coord_z = 32'hffffffff;
    send_word(w);
    w.coord_x = 32'h0000ffff; w.coord_y = 32'h00008000; w.coord_z = 32'h00010000;
    send_word(w);
    w.mode = MODE_TURB; send_word(w);
    w.mode = 2'd3; send_word(w);
    w.mode = MODE_NOISE; w.coord_x = 32'hffff0000; send_word(w);
    set_octaves(4'd0);
    w.mode = MODE_TURB; send_word(w);
    set_octaves(4'd15);
    send_word(w);
    set_octaves(4'd8);
    w.coord_x = 32'h80000000; w.coord_y = 32'h7fffffff; send_word(w);
    set_octaves(4'd1);
    drain();
  endtask

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    int r;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 15) send_word(make_load($urandom_range(ENTRIES - 1), $urandom_range(255)));
      else if (r < 70) send_word(make_point(MODE_NOISE));
      else if (r < 95) send_word(make_point(MODE_TURB));
      else send_word(make_point(2'd3));
    end
    drain();
  endtask

  task automatic test_random;
    random_phase(300, 0, 0);
    random_phase(200, 74, 0);
    set_octaves(4'd3);
    random_phase(200, 0, 74);
    set_octaves(4'($urandom_range(15)));
    random_phase(200, 19, 19);
    set_octaves(4'd1);
    random_phase(170, 19, 19);
  endtask

  // hold the result side back so the queue fills, then pause until clear
  task automatic test_backpressure;
    in_word_t w;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_recv = 1'b1;
    fork
      begin
        for (int i = 0; i < 8; i++) begin
          w = make_point(MODE_NOISE);
          send_word(w);
        end
      end
      begin
        repeat (3000) @(posedge clk);
        hold_recv = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd1;
    hold_recv = 1'b0;
    fails = 0; n_noise = 0; n_turb = 0; n_load = 0;
    oct_reg = 4'd1;
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < ENTRIES; i++) perm[9'(i)] = 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    $display("covered %0d table loads, %0d noise and %0d turbulence words",
             n_load, n_noise, n_turb);
    $display("octave counts 0, 1, 3, 8, 15 and one random; four idling mixes");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
